FILE: rtl/core/scp_pkg.sv
// shared constants and types for the stepper command parser
// no dependencies; imported by stepper_command_parser
`default_nettype none

package scp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned ArgW   = 2;
  localparam int unsigned MotorW = 2;
  localparam int unsigned StepsW = 15;
  localparam int unsigned AccW   = 14;
  localparam int unsigned DigitW = 4;

  // result beat: 21 payload bits padded to three bytes
  localparam int unsigned ResW   = KindW + ArgW + MotorW + StepsW;
  localparam int unsigned OutW   = ((ResW + 7) / 8) * 8;

  // command bytes
  localparam logic [ByteW-1:0] ChRelay = 8'h72;  // r
  localparam logic [ByteW-1:0] ChTrans = 8'h74;  // t
  localparam logic [ByteW-1:0] ChDrive = 8'h64;  // d
  localparam logic [ByteW-1:0] ChMotor = 8'h6d;  // m
  localparam logic [ByteW-1:0] ChMinus = 8'h2d;  // -
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChOne   = 8'h31;
  localparam logic [ByteW-1:0] ChTwo   = 8'h32;
  localparam logic [ByteW-1:0] ChThree = 8'h33;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;

  // decimal place weights
  localparam logic [AccW-1:0] Weight1000 = 14'd1000;
  localparam logic [AccW-1:0] Weight100  = 14'd100;
  localparam logic [AccW-1:0] Weight10   = 14'd10;

  typedef enum logic [KindW-1:0] {
    KIND_RELAY = 2'd0,
    KIND_TRANS = 2'd1,
    KIND_DRIVE = 2'd2,
    KIND_MOVE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [StepsW-1:0] signed_steps;
    logic [MotorW-1:0] motor_number;
    logic [ArgW-1:0]   switch_or_sequence;
    kind_t             command_kind;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/stepper_command_parser.sv
// stepper command parser: byte stream in, decoded command beats out
// depends on scp_pkg
`default_nettype none

// Takes one ASCII character per input beat and decodes the commands
// "r0"/"r1" (relay), "t0"/"t1" (transistor), "d0".."d2" (drive sequence)
// and "m" n [-] dddd (move motor n = 1..3 by a signed four-digit count).
// Each completed command leaves exactly one output beat; every other byte
// leaves nothing. An unexpected byte inside a command drops back to idle
// without being looked at as the start of a new command. One byte is
// taken every clock cycle: the parser state advances by combinational
// next-state logic, and the result goes to an output register backed by a
// one-entry skid register, so s_axis_tready only falls when both hold a
// beat that the downstream side has not taken yet. A result is registered
// in the output register, or in the skid register while the output stalls.
module stepper_command_parser (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [scp_pkg::ByteW-1:0] s_axis_tdata,  // [7:0] rx_byte
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // [1:0] command_kind, [3:2] switch_or_sequence, [5:4] motor_number,
  // [20:6] signed_steps, [23:21] zero
  output logic [scp_pkg::OutW-1:0]       m_axis_tdata
);
  import scp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_RELAY = 4'd1,
    ST_TRANS = 4'd2,
    ST_DRIVE = 4'd3,
    ST_MSEL  = 4'd4,
    ST_MSIGN = 4'd5,
    ST_MD100 = 4'd6,
    ST_MD10  = 4'd7,
    ST_MD1   = 4'd8
  } state_t;

  // parser state
  state_t            state, state_next;
  logic [MotorW-1:0] motor, motor_next;
  logic              reverse, reverse_next;
  logic [AccW-1:0]   acc, acc_next;

  // output register and skid register
  logic    out_valid;
  result_t out_res;
  logic    skid_valid;
  result_t skid_res;

  logic              accept;
  logic              res_valid;
  result_t           res;
  logic [ByteW-1:0]  ch;
  logic              is_digit;
  logic [DigitW-1:0] digit;
  logic [AccW-1:0]   digit_w;
  logic [AccW-1:0]   final_mag;

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign ch            = s_axis_tdata;
  // '0'..'9' share the high nibble, so the low nibble is the digit value
  assign is_digit      = (ch >= ChZero) && (ch <= ChNine);
  assign digit         = ch[DigitW-1:0];
  assign digit_w       = AccW'(digit);
  assign final_mag     = acc + digit_w;

  // next-state and result decode for the byte on the input
  always_comb begin
    state_next   = ST_IDLE;
    motor_next   = motor;
    reverse_next = reverse;
    acc_next     = acc;
    res_valid    = 1'b0;
    res          = '0;
    unique case (state)
      ST_IDLE: begin
        priority if (ch == ChRelay) begin
          state_next = ST_RELAY;
        end else if (ch == ChTrans) begin
          state_next = ST_TRANS;
        end else if (ch == ChDrive) begin
          state_next = ST_DRIVE;
        end else if (ch == ChMotor) begin
          state_next = ST_MSEL;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RELAY, ST_TRANS: begin
        if ((ch == ChZero) || (ch == ChOne)) begin
          res_valid                = 1'b1;
          res.command_kind         = (state == ST_RELAY) ? KIND_RELAY : KIND_TRANS;
          res.switch_or_sequence   = ch[ArgW-1:0];
        end
      end
      ST_DRIVE: begin
        if ((ch >= ChZero) && (ch <= ChTwo)) begin
          res_valid              = 1'b1;
          res.command_kind       = KIND_DRIVE;
          res.switch_or_sequence = ch[ArgW-1:0];
        end
      end
      ST_MSEL: begin
        if ((ch >= ChOne) && (ch <= ChThree)) begin
          motor_next   = ch[MotorW-1:0];
          reverse_next = 1'b0;
          state_next   = ST_MSIGN;
        end
      end
      ST_MSIGN: begin
        priority if (is_digit) begin
          acc_next   = digit_w * Weight1000;
          state_next = ST_MD100;
        end else if ((ch == ChMinus) && !reverse) begin
          reverse_next = 1'b1;
          state_next   = ST_MSIGN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_MD100: begin
        if (is_digit) begin
          acc_next   = acc + digit_w * Weight100;
          state_next = ST_MD10;
        end
      end
      ST_MD10: begin
        if (is_digit) begin
          acc_next   = acc + digit_w * Weight10;
          state_next = ST_MD1;
        end
      end
      ST_MD1: begin
        if (is_digit) begin
          acc_next          = final_mag;
          res_valid         = 1'b1;
          res.command_kind  = KIND_MOVE;
          res.motor_number  = motor;
          // negative zero comes out as plain zero
          res.signed_steps  = reverse ? (StepsW'(0) - {1'b0, final_mag})
                                      : {1'b0, final_mag};
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      motor      <= '0;
      reverse    <= 1'b0;
      acc        <= '0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        state   <= state_next;
        motor   <= motor_next;
        reverse <= reverse_next;
        acc     <= acc_next;
      end
      // output slot free or emptied this cycle: refill from skid first
      if (!out_valid || m_axis_tready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          out_res    <= skid_res;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= accept && res_valid;
          out_res   <= res;
        end
      end else if (accept && res_valid) begin
        // output stalled: park the new result
        skid_valid <= 1'b1;
        skid_res   <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OutW - ResW)'(0), out_res};

  // skid only fills behind a stalled output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a beat with the output empty");

  // a stalled full pipeline keeps the skid beat
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !m_axis_tready) |=> (skid_valid && $stable(skid_res)))
    else $error("skid beat lost while output stalled");

  // move results always address a real motor
  a_move_motor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.command_kind == KIND_MOVE)) |->
      (out_res.motor_number != '0))
    else $error("move result with motor zero");

  // switch and sequence results carry no motor or step count
  a_plain_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_res.command_kind != KIND_MOVE)) |->
      ((out_res.motor_number == '0) && (out_res.signed_steps == '0)))
    else $error("non-move result carries motor fields");

  // a result can only follow the final byte of a command
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid) |->
      ((state == ST_RELAY) || (state == ST_TRANS) || (state == ST_DRIVE) ||
       (state == ST_MD1)))
    else $error("result decoded in a state that ends no command");

endmodule

`default_nettype wire
